// File: src/alpha_blend_rect_fill_top_assert.svh
// Assertion macros used by the checker file of the blend/fill engine.
// No dependencies; included by bare file name.
`ifndef ALPHA_BLEND_RECT_FILL_TOP_ASSERT_SVH
`define ALPHA_BLEND_RECT_FILL_TOP_ASSERT_SVH

// same-cycle implication
`define ABRF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// next-cycle implication
`define ABRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// File: src/abrf_pkg.sv
// Package for the alpha blend / rectangle fill engine: sizes, codes, item types.
// No dependencies.
`timescale 1ns / 1ps

package abrf_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int PIXEL_BITS = 32;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // coordinate width: holds an exclusive edge and x_pos + rect_width
  localparam int CW0 = ((XW > YW) ? XW : YW) + 1;
  localparam int CW  = (CW0 > 11) ? CW0 : 11;

  localparam int CNT_W     = 19;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_BLEND  = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_PWRITE = 2'd2;
  localparam logic [1:0] KIND_PREAD  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 2'd1;

  localparam logic [CFG_W-1:0] SCREEN_RESET = 10'd512;
  localparam logic [7:0]       CH_MAX       = 8'hFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  x_pos;
    logic [8:0]  y_pos;
    logic [9:0]  rect_width;
    logic [9:0]  rect_height;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] raw_color;
  } abrf_cmd_t;

  typedef struct packed {
    logic [31:0]      read_data;
    logic [CNT_W-1:0] pixels_written;
  } abrf_result_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_CHK,
    S_SA_MUL, S_SA_EST, S_SA_FIX,
    S_RD, S_MUL1, S_MUL2, S_EST1, S_FIX1, S_MOVE, S_EST2, S_FIX2, S_WR,
    S_CLR, S_PWR, S_PRD, S_PRD_WAIT, S_DONE
  } abrf_state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_MUL, OP_EST, OP_FIX, OP_MOVE
  } abrf_op_t;

endpackage

// File: src/alpha_blend_rect_fill_top.sv
// channel   | signals                                  | handshake
// command   | start, busy, command (abrf_cmd_t)        | accepted when start && !busy
// result    | done, result (abrf_result_t)             | one-cycle strobe, no backpressure
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data| write when cfg_valid && cfg_ready
//
// Blend fill works one clipped pixel at a time, paced by the single 16x8 multiply /
// divide-by-255 unit that the sequencer reuses per channel. Clear writes each pixel
// through the framebuffer write port. A pixel write or read off screen goes straight to
// done. busy stays high from accept through the done cycle. Sync reset, active high;
// framebuffer contents are not cleared by reset.
// Depends on abrf_pkg.
`timescale 1ns / 1ps

module alpha_blend_rect_fill_top
  import abrf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  abrf_cmd_t            command,
  output logic                 done,
  output abrf_result_t         result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  abrf_state_t state, state_next;
  abrf_cmd_t   cmd, cmd_next;

  logic [CFG_W-1:0] screen_w, screen_h;
  logic [CW-1:0]    w_act, h_act, sw_ext, sh_ext;
  logic [CW-1:0]    cx, cy, x0, xe, ye;
  logic [CW-1:0]    cx_next, cy_next, x0_next, xe_next, ye_next;
  logic [CW-1:0]    x_ext, y_ext, xe_raw, ye_raw, cx_inc, cy_inc;
  logic [1:0]       ch, ch_next, lane;
  logic [2:0][7:0]  sa, sa_next;
  logic [31:0]      npix, npix_next;
  logic [31:0]      rdd, rdd_next;
  logic [CNT_W-1:0] count, count_next;

  // shared arithmetic unit
  abrf_op_t    op;
  logic [15:0] mul_a;
  logic [7:0]  mul_b;
  logic [23:0] acc, acc_next, mul_p, quo_x255, rem;
  logic [24:0] est_sum;
  logic [15:0] quo, quo_next, fix_q;

  // framebuffer
  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rdata, mem_wdata;
  logic [AW-1:0]         mem_addr;
  logic                  mem_we, mem_re;

  logic [7:0] da, dbyte, src;
  logic       in_screen;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign result.read_data      = rdd;
  assign result.pixels_written = count;

  assign sw_ext = CW'(screen_w);
  assign sh_ext = CW'(screen_h);
  assign w_act  = (sw_ext > CW'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : sw_ext;
  assign h_act  = (sh_ext > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : sh_ext;

  assign x_ext     = CW'(cmd.x_pos);
  assign y_ext     = CW'(cmd.y_pos);
  assign xe_raw    = x_ext + CW'(cmd.rect_width);
  assign ye_raw    = y_ext + CW'(cmd.rect_height);
  assign in_screen = (x_ext < w_act) && (y_ext < h_act);
  assign cx_inc    = cx + CW'(1);
  assign cy_inc    = cy + CW'(1);

  assign mem_addr = {cy[YW-1:0], cx[XW-1:0]};
  assign lane     = 2'd3 - ch;
  assign da       = rdata[31:24];
  assign dbyte    = rdata[{lane, 3'b000} +: 8];

  always_comb begin
    case (ch)
      2'd1:    src = cmd.red;
      2'd2:    src = cmd.green;
      2'd3:    src = cmd.blue;
      default: src = cmd.red;
    endcase
  end

  // multiply, divide-by-255 estimate, and one-step correction
  always_comb begin
    mul_p    = mul_a * mul_b;
    est_sum  = {1'b0, acc} + {9'd0, acc[23:8]} + {17'd0, acc[23:16]};
    quo_x255 = {quo, 8'd0} - {8'd0, quo};
    rem      = acc - quo_x255;
    fix_q    = (rem >= 24'd255) ? (quo + 16'd1) : quo;
    acc_next = acc;
    quo_next = quo;
    case (op)
      OP_MUL:  acc_next = mul_p;
      OP_EST:  quo_next = est_sum[23:8];
      OP_FIX:  quo_next = fix_q;
      OP_MOVE: acc_next = {8'd0, quo};
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    cx_next    = cx;
    cy_next    = cy;
    x0_next    = x0;
    xe_next    = xe;
    ye_next    = ye;
    ch_next    = ch;
    sa_next    = sa;
    npix_next  = npix;
    rdd_next   = rdd;
    count_next = count;
    op         = OP_NONE;
    mul_a      = 16'd0;
    mul_b      = 8'd0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = npix;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next   = command;
          rdd_next   = 32'd0;
          count_next = '0;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        case (cmd.kind)
          KIND_BLEND: begin
            x0_next    = x_ext;
            cx_next    = x_ext;
            cy_next    = y_ext;
            xe_next    = (xe_raw > w_act) ? w_act : xe_raw;
            ye_next    = (ye_raw > h_act) ? h_act : ye_raw;
            state_next = S_CHK;
          end
          KIND_CLEAR: begin
            x0_next    = '0;
            cx_next    = '0;
            cy_next    = '0;
            xe_next    = w_act;
            ye_next    = h_act;
            state_next = S_CHK;
          end
          KIND_PWRITE: begin
            cx_next    = x_ext;
            cy_next    = y_ext;
            state_next = in_screen ? S_PWR : S_DONE;
          end
          default: begin
            cx_next    = x_ext;
            cy_next    = y_ext;
            state_next = in_screen ? S_PRD : S_DONE;
          end
        endcase
      end
      S_CHK: begin
        if ((cx >= xe) || (cy >= ye)) begin
          state_next = S_DONE;
        end else if (cmd.kind == KIND_BLEND) begin
          ch_next    = 2'd1;
          state_next = S_SA_MUL;
        end else begin
          state_next = S_CLR;
        end
      end
      S_SA_MUL: begin
        op         = OP_MUL;
        mul_a      = {8'd0, src};
        mul_b      = cmd.alpha;
        state_next = S_SA_EST;
      end
      S_SA_EST: begin
        op         = OP_EST;
        state_next = S_SA_FIX;
      end
      S_SA_FIX: begin
        op                   = OP_FIX;
        sa_next[ch - 2'd1]   = fix_q[7:0];
        if (ch == 2'd3) begin
          ch_next    = 2'd0;
          state_next = S_RD;
        end else begin
          ch_next    = ch + 2'd1;
          state_next = S_SA_MUL;
        end
      end
      S_RD: begin
        mem_re     = 1'b1;
        ch_next    = 2'd0;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        op = OP_MUL;
        if (ch == 2'd0) begin
          mul_a      = {8'd0, CH_MAX - da};
          mul_b      = cmd.alpha;
          state_next = S_EST1;
        end else begin
          mul_a      = {8'd0, dbyte};
          mul_b      = da;
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        op         = OP_MUL;
        mul_a      = acc[15:0];
        mul_b      = CH_MAX - cmd.alpha;
        state_next = S_EST1;
      end
      S_EST1: begin
        op         = OP_EST;
        state_next = S_FIX1;
      end
      S_FIX1: begin
        op = OP_FIX;
        if (ch == 2'd0) begin
          npix_next[31:24] = da + fix_q[7:0];
          ch_next          = 2'd1;
          state_next       = S_MUL1;
        end else begin
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        op         = OP_MOVE;
        state_next = S_EST2;
      end
      S_EST2: begin
        op         = OP_EST;
        state_next = S_FIX2;
      end
      S_FIX2: begin
        op = OP_FIX;
        npix_next[{lane, 3'b000} +: 8] = sa[ch - 2'd1] + fix_q[7:0];
        if (ch == 2'd3) begin
          state_next = S_WR;
        end else begin
          ch_next    = ch + 2'd1;
          state_next = S_MUL1;
        end
      end
      S_WR: begin
        mem_we     = 1'b1;
        count_next = count + CNT_W'(1);
        state_next = S_RD;
        if (cx_inc >= xe) begin
          cx_next = x0;
          cy_next = cy_inc;
          if (cy_inc >= ye) begin
            state_next = S_DONE;
          end
        end else begin
          cx_next = cx_inc;
        end
      end
      S_CLR: begin
        mem_we     = 1'b1;
        mem_wdata  = {CH_MAX, cmd.red, cmd.green, cmd.blue};
        count_next = count + CNT_W'(1);
        if (cx_inc >= xe) begin
          cx_next = x0;
          cy_next = cy_inc;
          if (cy_inc >= ye) begin
            state_next = S_DONE;
          end
        end else begin
          cx_next = cx_inc;
        end
      end
      S_PWR: begin
        mem_we     = 1'b1;
        mem_wdata  = cmd.raw_color;
        count_next = CNT_W'(1);
        state_next = S_DONE;
      end
      S_PRD: begin
        mem_re     = 1'b1;
        state_next = S_PRD_WAIT;
      end
      S_PRD_WAIT: begin
        rdd_next   = rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd   <= cmd_next;
    cx    <= cx_next;
    cy    <= cy_next;
    x0    <= x0_next;
    xe    <= xe_next;
    ye    <= ye_next;
    ch    <= ch_next;
    sa    <= sa_next;
    npix  <= npix_next;
    rdd   <= rdd_next;
    count <= count_next;
    acc   <= acc_next;
    quo   <= quo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_w <= SCREEN_RESET;
      screen_h <= SCREEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_W: screen_w <= cfg_data;
        REG_SCREEN_H: screen_h <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

endmodule

// File: src/abrf_checker.sv
// Port-level checker for the blend/fill engine, bound to the top level.
// Depends on abrf_pkg and alpha_blend_rect_fill_top_assert.svh.
`timescale 1ns / 1ps
`include "alpha_blend_rect_fill_top_assert.svh"

module abrf_checker
  import abrf_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         start,
  input logic         busy,
  input logic         done,
  input abrf_result_t result
);

  logic [CNT_W-1:0] cnt_seen;
  assign cnt_seen = result.pixels_written;

  // an accepted item raises busy
  `ABRF_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ABRF_ASSERT_NOW(a_done_busy, clk, rst, done, busy && (cnt_seen == cnt_seen))
  `ABRF_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy)
  // busy only rises after an accept
  `ABRF_ASSERT_NOW(a_busy_cause, clk, rst, $rose(busy), $past(start))

endmodule

bind alpha_blend_rect_fill_top abrf_checker u_abrf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
